// File: rtl/qsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qsi_pkg;

  // fixed point constants
  localparam int CordicIters = 24;
  localparam int DivSteps    = 31;
  localparam int VelSteps    = 5;
  localparam logic [5:0] StepCountReset = 6'd50;

  localparam logic signed [27:0] AngPi     = 28'sd52707179;
  localparam logic signed [27:0] AngHalfPi = 28'sd26353589;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  // register indexes
  localparam logic RegStepCount = 1'b0;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANG_LOAD,
    ST_CORDIC,
    ST_TRIG_STORE,
    ST_VEL,
    ST_COEF,
    ST_DIV_LOAD,
    ST_DIV,
    ST_ACC_INIT,
    ST_EVAL,
    ST_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       load_ang;
    logic       cordic_step;
    logic       trig_store;
    logic       vel_step;
    logic       coef_load;
    logic       div_load;
    logic       div_step;
    logic       acc_init;
    logic       eval_en;
    logic       out_load;
    logic       sel;
    logic       axis;
    logic [4:0] iter;
    logic [2:0] k;
    logic [1:0] phase;
    logic [6:0] pidx;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_full;
    logic is_last;
  } status_t;

  // arctangent table, q.24
  function automatic logic signed [27:0] atan_q24(input logic [4:0] i);
    logic signed [27:0] r;
    case (i)
      5'd0:  r = 28'sd13176795;
      5'd1:  r = 28'sd7778716;
      5'd2:  r = 28'sd4110060;
      5'd3:  r = 28'sd2086331;
      5'd4:  r = 28'sd1047214;
      5'd5:  r = 28'sd524117;
      5'd6:  r = 28'sd262123;
      5'd7:  r = 28'sd131069;
      5'd8:  r = 28'sd65536;
      5'd9:  r = 28'sd32768;
      5'd10: r = 28'sd16384;
      5'd11: r = 28'sd8192;
      5'd12: r = 28'sd4096;
      5'd13: r = 28'sd2048;
      5'd14: r = 28'sd1024;
      5'd15: r = 28'sd512;
      5'd16: r = 28'sd256;
      5'd17: r = 28'sd128;
      5'd18: r = 28'sd64;
      5'd19: r = 28'sd32;
      5'd20: r = 28'sd16;
      5'd21: r = 28'sd8;
      5'd22: r = 28'sd4;
      5'd23: r = 28'sd2;
      default: r = 28'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/qsi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module qsi_ctrl
  import qsi_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t     state, state_next;
  logic [4:0] iter;
  logic       sel;
  logic       axis;
  logic [2:0] k;
  logic [1:0] phase;
  logic [6:0] pidx;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:       if (in_valid) state_next = ST_ANG_LOAD;
      ST_ANG_LOAD:   state_next = ST_CORDIC;
      ST_CORDIC:     if (iter == 5'(CordicIters - 1)) state_next = ST_TRIG_STORE;
      ST_TRIG_STORE: state_next = sel ? ST_VEL : ST_ANG_LOAD;
      ST_VEL:        if (iter == 5'(VelSteps - 1)) state_next = ST_COEF;
      ST_COEF:       state_next = ST_DIV_LOAD;
      ST_DIV_LOAD:   state_next = ST_DIV;
      ST_DIV:        if (iter == 5'(DivSteps - 1)) state_next = ST_ACC_INIT;
      ST_ACC_INIT:   state_next = ST_EVAL;
      ST_EVAL: begin
        if (phase == 2'd2 && k == 3'd0) state_next = axis ? ST_OUT : ST_ACC_INIT;
      end
      ST_OUT: begin
        if (!status.out_full) state_next = status.is_last ? ST_IDLE : ST_DIV_LOAD;
      end
      default:       state_next = ST_IDLE;
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      iter  <= '0;
      sel   <= 1'b0;
      axis  <= 1'b0;
      k     <= '0;
      phase <= '0;
      pidx  <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          sel <= 1'b0;
        end
        ST_ANG_LOAD: iter <= '0;
        ST_CORDIC:   iter <= iter + 5'd1;
        ST_TRIG_STORE: begin
          sel  <= 1'b1;
          iter <= '0;
        end
        ST_VEL:      iter <= iter + 5'd1;
        ST_COEF:     pidx <= '0;
        ST_DIV_LOAD: iter <= '0;
        ST_DIV: begin
          iter <= iter + 5'd1;
          axis <= 1'b0;
        end
        ST_ACC_INIT: begin
          k     <= 3'd4;
          phase <= 2'd0;
        end
        ST_EVAL: begin
          if (phase == 2'd2) begin
            phase <= 2'd0;
            if (k == 3'd0) axis <= 1'b1;
            else k <= k - 3'd1;
          end else begin
            phase <= phase + 2'd1;
          end
        end
        ST_OUT: if (!status.out_full) pidx <= pidx + 7'd1;
        default: ;
      endcase
    end
  end

  // command outputs
  always_comb begin
    cmd          = '0;
    cmd.sel      = sel;
    cmd.axis     = axis;
    cmd.iter     = iter;
    cmd.k        = k;
    cmd.phase    = phase;
    cmd.pidx     = pidx;
    in_ready     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_ANG_LOAD:   cmd.load_ang    = 1'b1;
      ST_CORDIC:     cmd.cordic_step = 1'b1;
      ST_TRIG_STORE: cmd.trig_store  = 1'b1;
      ST_VEL:        cmd.vel_step    = 1'b1;
      ST_COEF:       cmd.coef_load   = 1'b1;
      ST_DIV_LOAD:   cmd.div_load    = 1'b1;
      ST_DIV:        cmd.div_step    = 1'b1;
      ST_ACC_INIT:   cmd.acc_init    = 1'b1;
      ST_EVAL:       cmd.eval_en     = 1'b1;
      ST_OUT:        cmd.out_load    = !status.out_full;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/qsi_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module qsi_datapath
  import qsi_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output status_t                 status,
  input  wire logic [5:0]         step_count,
  input  wire logic signed [31:0] start_x,
  input  wire logic signed [31:0] start_y,
  input  wire logic [30:0]        start_speed,
  input  wire logic signed [15:0] start_heading,
  input  wire logic signed [31:0] end_x,
  input  wire logic signed [31:0] end_y,
  input  wire logic [30:0]        end_speed,
  input  wire logic signed [15:0] end_heading,
  input  wire logic               include_end,
  output logic signed [31:0]      point_x,
  output logic signed [31:0]      point_y,
  output logic                    last_point,
  output logic                    out_valid,
  input  wire logic               out_ready
);

  // latched segment
  logic signed [31:0] sx, sy, ex, ey;
  logic [30:0]        ss, es;
  logic signed [15:0] sh, eh;
  logic [5:0]         n;
  logic [6:0]         count;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sx    <= start_x;
      sy    <= start_y;
      ss    <= start_speed;
      sh    <= start_heading;
      ex    <= end_x;
      ey    <= end_y;
      es    <= end_speed;
      eh    <= end_heading;
      n     <= (step_count == 6'd0) ? 6'd1 : step_count;
      count <= ((step_count == 6'd0) ? 7'd1 : {1'b0, step_count}) + {6'd0, include_end};
    end
  end

  // cordic rotation
  logic signed [33:0] cx, cy;
  logic signed [27:0] cz;
  logic               cneg;
  logic signed [27:0] z_init;
  logic signed [33:0] dx, dy;

  assign z_init = $signed({{1{cmd.sel ? eh[15] : sh[15]}}, (cmd.sel ? eh : sh), 11'd0});
  assign dx     = cy >>> cmd.iter;
  assign dy     = cx >>> cmd.iter;

  always_ff @(posedge clk) begin
    if (cmd.load_ang) begin
      cx <= CordicGain;
      cy <= '0;
      if (z_init > AngHalfPi) begin
        cz   <= z_init - AngPi;
        cneg <= 1'b1;
      end else if (z_init < -AngHalfPi) begin
        cz   <= z_init + AngPi;
        cneg <= 1'b1;
      end else begin
        cz   <= z_init;
        cneg <= 1'b0;
      end
    end else if (cmd.cordic_step) begin
      if (!cz[27]) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - atan_q24(cmd.iter);
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + atan_q24(cmd.iter);
      end
    end
  end

  // sine and cosine of both headings
  logic signed [31:0] ssin, scos, esin, ecos;
  logic signed [33:0] sin_v, cos_v;

  assign sin_v = cneg ? -cy : cy;
  assign cos_v = cneg ? -cx : cx;

  always_ff @(posedge clk) begin
    if (cmd.trig_store) begin
      if (cmd.sel) begin
        esin <= sin_v[31:0];
        ecos <= cos_v[31:0];
      end else begin
        ssin <= sin_v[31:0];
        scos <= cos_v[31:0];
      end
    end
  end

  // velocity components: x start, y start, x end, y end
  logic signed [32:0] vel [4];
  logic signed [63:0] prod;
  logic signed [31:0] mul_speed, mul_trig;
  logic signed [63:0] prod_rnd;

  always_comb begin
    case (cmd.iter[1:0])
      2'd0:    begin mul_speed = $signed({1'b0, ss}); mul_trig = ssin; end
      2'd1:    begin mul_speed = $signed({1'b0, ss}); mul_trig = scos; end
      2'd2:    begin mul_speed = $signed({1'b0, es}); mul_trig = esin; end
      default: begin mul_speed = $signed({1'b0, es}); mul_trig = ecos; end
    endcase
  end

  assign prod_rnd = (prod + 64'sd536870912) >>> 30;

  always_ff @(posedge clk) begin
    if (cmd.vel_step) begin
      if (cmd.iter < 5'd4) prod <= mul_speed * mul_trig;
      if (cmd.iter != 5'd0) vel[2'(cmd.iter - 5'd1)] <= prod_rnd[32:0];
    end
  end

  // quintic coefficients per axis
  logic signed [39:0] coef [2][6];
  logic signed [39:0] ux, vx, uy, vy;

  assign ux = 40'(ex) - 40'(sx) - 40'(vel[0]);
  assign vx = 40'(vel[2]) - 40'(vel[0]);
  assign uy = 40'(ey) - 40'(sy) - 40'(vel[1]);
  assign vy = 40'(vel[3]) - 40'(vel[1]);

  always_ff @(posedge clk) begin
    if (cmd.coef_load) begin
      coef[0][0] <= 40'(sx);
      coef[0][1] <= 40'(vel[0]);
      coef[0][2] <= '0;
      coef[0][3] <= 40'sd10 * ux - 40'sd4 * vx;
      coef[0][4] <= 40'sd7 * vx - 40'sd15 * ux;
      coef[0][5] <= 40'sd6 * ux - 40'sd3 * vx;
      coef[1][0] <= 40'(sy);
      coef[1][1] <= 40'(vel[1]);
      coef[1][2] <= '0;
      coef[1][3] <= 40'sd10 * uy - 40'sd4 * vy;
      coef[1][4] <= 40'sd7 * vy - 40'sd15 * uy;
      coef[1][5] <= 40'sd6 * uy - 40'sd3 * vy;
    end
  end

  // t = (i * 2^24 + n/2) / n by restoring division
  logic [5:0]  rem;
  logic [30:0] dq;
  logic [6:0]  trial;
  logic        qbit;

  assign trial = {rem, dq[30]};
  assign qbit  = (trial >= {1'b0, n});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem <= '0;
      dq  <= {cmd.pidx, 24'd0} + {26'd0, n[5:1]};
    end else if (cmd.div_step) begin
      rem <= qbit ? 6'(trial - {1'b0, n}) : trial[5:0];
      dq  <= {dq[29:0], qbit};
    end
  end

  // horner evaluation, acc * t in two partial products
  logic signed [41:0] acc;
  logic signed [47:0] plo, phi;
  logic signed [21:0] mul_a;
  logic signed [25:0] mul_t;
  logic signed [47:0] mul_p;
  logic signed [67:0] hsum;
  logic signed [67:0] hshift;
  logic signed [41:0] acc_new;
  logic signed [31:0] sat_new;
  logic signed [31:0] res_x, res_y;

  assign mul_a   = (cmd.phase == 2'd0) ? $signed({1'b0, acc[20:0]}) : $signed({acc[41], acc[41:21]});
  assign mul_t   = $signed({1'b0, dq[24:0]});
  assign mul_p   = mul_a * mul_t;
  assign hsum    = (68'(phi) <<< 21) + 68'(plo) + 68'sd8388608;
  assign hshift  = hsum >>> 24;
  assign acc_new = 42'(coef[cmd.axis][cmd.k]) + hshift[41:0];

  always_comb begin
    if (acc_new > 42'sd2147483647) sat_new = 32'sh7fffffff;
    else if (acc_new < -42'sd2147483648) sat_new = 32'sh80000000;
    else sat_new = acc_new[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_init) begin
      acc <= 42'(coef[cmd.axis][5]);
    end else if (cmd.eval_en) begin
      case (cmd.phase)
        2'd0: plo <= mul_p;
        2'd1: phi <= mul_p;
        default: begin
          acc <= acc_new;
          if (cmd.k == 3'd0) begin
            if (cmd.axis) res_y <= sat_new;
            else res_x <= sat_new;
          end
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      point_x    <= res_x;
      point_y    <= res_y;
      last_point <= status.is_last;
    end
  end

  assign status.out_full = out_valid & ~out_ready;
  assign status.is_last  = (cmd.pidx == count - 7'd1);

endmodule
`default_nettype wire

// File: rtl/quintic_segment_interpolator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// quintic segment interpolator
// input channel (in_valid/in_ready) takes one segment item: start and end
// positions, speeds and headings, and include_end. output channel
// (out_valid/out_ready) gives step_count points per segment (one when
// step_count is zero), one more when include_end is set, with last_point
// high on the final one. step_count is written over the apb port at
// address 0; the user writes it only while idle, not enforced by the block.
// setup per segment after the item is taken is two 24-step cordic passes
// on one shared rotator, four velocity products on one multiplier and one
// coefficient load step. each point then takes a 31-step bit-serial
// divide for t and two axes of five horner steps, three phases each on
// one 22x26 multiplier.
// a finished point sits in an output register; the next point waits in the
// datapath until that register is taken, and the next segment is accepted
// once the last point is in the output register.
// synchronous reset returns to idle, drops out_valid and sets step_count
// to 50.
module quintic_segment_interpolator_unit
  import qsi_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] start_x,
  input  wire logic signed [31:0] start_y,
  input  wire logic [30:0]        start_speed,
  input  wire logic signed [15:0] start_heading,
  input  wire logic signed [31:0] end_x,
  input  wire logic signed [31:0] end_y,
  input  wire logic [30:0]        end_speed,
  input  wire logic signed [15:0] end_heading,
  input  wire logic               include_end,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      point_x,
  output logic signed [31:0]      point_y,
  output logic                    last_point
);

  logic [5:0] step_count;
  cmd_t       cmd;
  status_t    status;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= StepCountReset;
    end else if (psel && penable && pwrite && paddr[2] == RegStepCount) begin
      step_count <= pwdata[5:0];
    end
  end

  assign prdata = (paddr[2] == RegStepCount) ? {26'd0, step_count} : 32'd0;

  qsi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  qsi_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .step_count    (step_count),
    .start_x       (start_x),
    .start_y       (start_y),
    .start_speed   (start_speed),
    .start_heading (start_heading),
    .end_x         (end_x),
    .end_y         (end_y),
    .end_speed     (end_speed),
    .end_heading   (end_heading),
    .include_end   (include_end),
    .point_x       (point_x),
    .point_y       (point_y),
    .last_point    (last_point),
    .out_valid     (out_valid),
    .out_ready     (out_ready)
  );

endmodule
`default_nettype wire
